### rtl/core/pip_pkg.sv
// shared types, constants and helpers for the point-in-polygon crossing test
`timescale 1ns / 1ps

package pip_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int COORD_W      = 32;
    localparam int PROD_W       = 2 * COORD_W;

    // request command codes
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEST   = 2'd2
    } cmd_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_LAST,
        ST_EDGE,
        ST_MUL_A,
        ST_MUL_B,
        ST_CMP
    } state_t;

    // sign-magnitude difference of two coordinates
    typedef struct packed {
        logic               neg;
        logic [COORD_W-1:0] mag;
    } diff_t;

    // sign-magnitude product
    typedef struct packed {
        logic              neg;
        logic [PROD_W-1:0] mag;
    } prod_t;

    // u - v as sign and magnitude; the magnitude always fits in COORD_W bits
    function automatic diff_t abs_diff(input logic signed [COORD_W-1:0] u,
                                       input logic signed [COORD_W-1:0] v);
        diff_t d;
        d.neg = (u < v);
        d.mag = d.neg ? COORD_W'(v - u) : COORD_W'(u - v);
        return d;
    endfunction

    // exact compare p >= q of two sign-magnitude products
    function automatic logic prod_ge(input prod_t p, input prod_t q);
        logic ge;
        if (!p.neg && q.neg) begin
            ge = 1'b1;
        end
        else if (p.neg && !q.neg) begin
            ge = 1'b0;
        end
        else if (!p.neg) begin
            ge = (p.mag >= q.mag);
        end
        else begin
            ge = (p.mag <= q.mag);
        end
        return ge;
    endfunction

endpackage

### rtl/core/pip_vstore.sv
// vertex store: one write port, one registered read port
`timescale 1ns / 1ps

module pip_vstore (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [pip_pkg::ADDR_W-1:0]                wr_addr,
    input  logic signed [pip_pkg::COORD_W-1:0]        wr_x,
    input  logic signed [pip_pkg::COORD_W-1:0]        wr_y,
    input  logic                                      rd_en,
    input  logic [pip_pkg::ADDR_W-1:0]                rd_addr,
    output logic signed [pip_pkg::COORD_W-1:0]        rd_x,
    output logic signed [pip_pkg::COORD_W-1:0]        rd_y
);

    logic [2*pip_pkg::COORD_W-1:0] mem [pip_pkg::MAX_VERTICES];
    logic [2*pip_pkg::COORD_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_x, wr_y};
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_x = rd_data_reg[2*pip_pkg::COORD_W-1:pip_pkg::COORD_W];
    assign rd_y = rd_data_reg[pip_pkg::COORD_W-1:0];

endmodule

### rtl/core/pip_mul.sv
// shared sign-magnitude multiplier with registered product
`timescale 1ns / 1ps

module pip_mul (
    input  logic                   clk,
    input  pip_pkg::diff_t         op_a,
    input  pip_pkg::diff_t         op_b,
    output pip_pkg::prod_t         prod
);

    pip_pkg::prod_t prod_reg;
    pip_pkg::prod_t prod_next;

    // 32x32 unsigned magnitude product, sign only when nonzero
    always_comb
    begin
        prod_next.mag = pip_pkg::PROD_W'(op_a.mag) * pip_pkg::PROD_W'(op_b.mag);
        prod_next.neg = (op_a.neg ^ op_b.neg) && (op_a.mag != '0) && (op_b.mag != '0);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

### rtl/core/point_in_polygon_crossing_test.sv
// top level: vertex store control and edge-walking sequencer for the crossing test
//
// Request channel (req_valid/req_ready) carries command, coord_x, coord_y:
// clear drops all vertices, append stores one vertex at the end of the list,
// test checks the point against the closed polygon held in the store.
// Every request yields exactly one response on rsp_valid/rsp_ready with
// inside_res, status (1 when an append hit a full store) and vertex_total.
// Clear, append, unused codes and a test on an empty polygon answer in the
// cycle after acceptance. A test walks the edges with one store read per
// cycle while no edge is in the multiplier; each edge whose end points
// straddle the point's y-level goes through the shared 32x32 multiplier
// (two products, one compare), which holds the walk until it is done.
// The walk is bounded by the single store read port and the one multiplier.
// One request is in work at a time; req_ready is low while a test runs.
// A waiting response does not block the next request if it is taken in the
// same cycle; while rsp_ready stays low the response holds and no request
// is taken. Reset empties the polygon; store contents are not cleared.
`timescale 1ns / 1ps

module point_in_polygon_crossing_test (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  logic [1:0]                           command,
    input  logic signed [pip_pkg::COORD_W-1:0]   coord_x,
    input  logic signed [pip_pkg::COORD_W-1:0]   coord_y,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output logic                                 inside_res,
    output logic                                 status,
    output logic [pip_pkg::CNT_W-1:0]            vertex_total
);

    pip_pkg::state_t                      state_reg, state_next;
    logic [pip_pkg::CNT_W-1:0]            count_reg, count_next;
    logic [pip_pkg::ADDR_W-1:0]           idx_reg, idx_next;
    logic                                 rsp_valid_reg, rsp_valid_next;
    logic                                 inside_reg, inside_next;
    logic                                 status_reg, status_next;
    logic [pip_pkg::CNT_W-1:0]            total_reg, total_next;
    logic                                 flag_reg, flag_next;
    logic                                 above_reg, above_next;
    logic signed [pip_pkg::COORD_W-1:0]   px_reg, px_next;
    logic signed [pip_pkg::COORD_W-1:0]   py_reg, py_next;
    logic signed [pip_pkg::COORD_W-1:0]   prev_x_reg, prev_x_next;
    logic signed [pip_pkg::COORD_W-1:0]   prev_y_reg, prev_y_next;
    logic signed [pip_pkg::COORD_W-1:0]   cur_x_reg, cur_x_next;
    logic signed [pip_pkg::COORD_W-1:0]   cur_y_reg, cur_y_next;
    pip_pkg::diff_t                       da_reg, da_next;
    pip_pkg::diff_t                       db_reg, db_next;
    pip_pkg::diff_t                       dc_reg, dc_next;
    pip_pkg::diff_t                       dd_reg, dd_next;
    pip_pkg::prod_t                       pa_reg, pa_next;

    logic                                 accept;
    logic [pip_pkg::CNT_W-1:0]            last_idx;
    logic                                 wr_en;
    logic                                 rd_en;
    logic [pip_pkg::ADDR_W-1:0]           rd_addr;
    logic signed [pip_pkg::COORD_W-1:0]   rd_x;
    logic signed [pip_pkg::COORD_W-1:0]   rd_y;
    pip_pkg::diff_t                       mul_a;
    pip_pkg::diff_t                       mul_b;
    pip_pkg::prod_t                       mul_p;
    logic                                 advance;
    logic signed [pip_pkg::COORD_W-1:0]   adv_x;
    logic signed [pip_pkg::COORD_W-1:0]   adv_y;
    logic                                 adv_above;
    logic                                 cur_above;

    assign req_ready = (state_reg == pip_pkg::ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign last_idx  = count_reg - pip_pkg::CNT_W'(1);
    assign wr_en     = accept && (pip_pkg::cmd_t'(command) == pip_pkg::CMD_APPEND)
                       && (count_reg < pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES));
    assign cur_above = (rd_y >= py_reg);

    // vertex store
    pip_vstore u_vstore (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[pip_pkg::ADDR_W-1:0]),
        .wr_x    (coord_x),
        .wr_y    (coord_y),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_x    (rd_x),
        .rd_y    (rd_y)
    );

    // shared multiplier
    pip_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    // next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rsp_valid_next = rsp_valid_reg;
        inside_next    = inside_reg;
        status_next    = status_reg;
        total_next     = total_reg;
        flag_next      = flag_reg;
        above_next     = above_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        da_next        = da_reg;
        db_next        = db_reg;
        dc_next        = dc_reg;
        dd_next        = dd_reg;
        pa_next        = pa_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        mul_a          = da_reg;
        mul_b          = db_reg;
        advance        = 1'b0;
        adv_x          = cur_x_reg;
        adv_y          = cur_y_reg;
        adv_above      = ~above_reg;

        // response taken
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            pip_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    inside_next = 1'b0;
                    status_next = 1'b0;
                    total_next  = count_reg;
                    unique case (pip_pkg::cmd_t'(command))
                        pip_pkg::CMD_CLEAR:
                        begin
                            count_next     = '0;
                            total_next     = '0;
                            rsp_valid_next = 1'b1;
                        end
                        pip_pkg::CMD_APPEND:
                        begin
                            if (wr_en)
                            begin
                                count_next = count_reg + pip_pkg::CNT_W'(1);
                                total_next = count_reg + pip_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                            rsp_valid_next = 1'b1;
                        end
                        pip_pkg::CMD_TEST:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_valid_next = 1'b1;
                            end
                            else
                            begin
                                px_next    = coord_x;
                                py_next    = coord_y;
                                flag_next  = 1'b0;
                                rd_en      = 1'b1;
                                rd_addr    = last_idx[pip_pkg::ADDR_W-1:0];
                                state_next = pip_pkg::ST_LOAD_LAST;
                            end
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            // last vertex opens the closing edge
            pip_pkg::ST_LOAD_LAST:
            begin
                prev_x_next = rd_x;
                prev_y_next = rd_y;
                above_next  = cur_above;
                idx_next    = '0;
                rd_en       = 1'b1;
                rd_addr     = '0;
                state_next  = pip_pkg::ST_EDGE;
            end

            // current vertex arrives; straddling edges go to the multiplier
            pip_pkg::ST_EDGE:
            begin
                cur_x_next = rd_x;
                cur_y_next = rd_y;
                if (cur_above != above_reg)
                begin
                    da_next    = pip_pkg::abs_diff(rd_y, py_reg);
                    db_next    = pip_pkg::abs_diff(prev_x_reg, rd_x);
                    dc_next    = pip_pkg::abs_diff(rd_x, px_reg);
                    dd_next    = pip_pkg::abs_diff(prev_y_reg, rd_y);
                    state_next = pip_pkg::ST_MUL_A;
                end
                else
                begin
                    advance   = 1'b1;
                    adv_x     = rd_x;
                    adv_y     = rd_y;
                    adv_above = cur_above;
                end
            end

            // first product in flight
            pip_pkg::ST_MUL_A:
            begin
                state_next = pip_pkg::ST_MUL_B;
            end

            // keep first product, second in flight
            pip_pkg::ST_MUL_B:
            begin
                pa_next    = mul_p;
                mul_a      = dc_reg;
                mul_b      = dd_reg;
                state_next = pip_pkg::ST_CMP;
            end

            // compare products against the current above flag
            pip_pkg::ST_CMP:
            begin
                if (pip_pkg::prod_ge(pa_reg, mul_p) == ~above_reg)
                begin
                    flag_next = ~flag_reg;
                end
                advance = 1'b1;
            end

            default:
            begin
                state_next = pip_pkg::ST_IDLE;
            end
        endcase

        // move to the next edge or finish the walk
        if (advance)
        begin
            prev_x_next = adv_x;
            prev_y_next = adv_y;
            above_next  = adv_above;
            if ({1'b0, idx_reg} == last_idx)
            begin
                inside_next    = flag_next;
                status_next    = 1'b0;
                total_next     = count_reg;
                rsp_valid_next = 1'b1;
                state_next     = pip_pkg::ST_IDLE;
            end
            else
            begin
                idx_next   = idx_reg + pip_pkg::ADDR_W'(1);
                rd_en      = 1'b1;
                rd_addr    = idx_reg + pip_pkg::ADDR_W'(1);
                state_next = pip_pkg::ST_EDGE;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pip_pkg::ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        inside_reg <= inside_next;
        status_reg <= status_next;
        total_reg  <= total_next;
        flag_reg   <= flag_next;
        above_reg  <= above_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        prev_x_reg <= prev_x_next;
        prev_y_reg <= prev_y_next;
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        da_reg     <= da_next;
        db_reg     <= db_next;
        dc_reg     <= dc_next;
        dd_reg     <= dd_next;
        pa_reg     <= pa_next;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign inside_res   = inside_reg;
    assign status       = status_reg;
    assign vertex_total = total_reg;

endmodule
